### hdl/rr_pkg.sv
`timescale 1ns / 1ps

package rr_pkg;

   // Code point width
   localparam int CP_W = 21;

   // Right-to-left blocks
   localparam logic [CP_W-1:0] ARABIC_LO     = 21'h000600;
   localparam logic [CP_W-1:0] ARABIC_HI     = 21'h0006FF;
   localparam logic [CP_W-1:0] ARABIC_SUP_LO = 21'h000750;
   localparam logic [CP_W-1:0] ARABIC_SUP_HI = 21'h00077F;
   localparam logic [CP_W-1:0] ARABIC_EXA_LO = 21'h0008A0;
   localparam logic [CP_W-1:0] ARABIC_EXA_HI = 21'h0008FF;
   localparam logic [CP_W-1:0] HEBREW_LO     = 21'h000590;
   localparam logic [CP_W-1:0] HEBREW_HI     = 21'h0005FF;
   localparam logic [CP_W-1:0] PRES_FORMS_LO = 21'h00FE70;
   localparam logic [CP_W-1:0] PRES_FORMS_HI = 21'h00FEFF;
   localparam logic [CP_W-1:0] CP_NEWLINE    = 21'h00000A;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_OUT,
      ST_EMIT,
      ST_PUSH
   } rr_state_type;

   // What follows once the held run has been released
   typedef enum logic [1:0] {
      NXT_EMIT,
      NXT_PUSH,
      NXT_DONE
   } rr_next_type;

   // Result handed from the sequencer to the output register
   typedef struct packed {
      logic            load;
      logic [CP_W-1:0] cp;
      logic            last;
   } rr_out_type;

   function automatic logic is_rtl(input logic [CP_W-1:0] cp);
      logic rtl;
      rtl = ((cp >= ARABIC_LO)     && (cp <= ARABIC_HI))     ||
            ((cp >= ARABIC_SUP_LO) && (cp <= ARABIC_SUP_HI)) ||
            ((cp >= ARABIC_EXA_LO) && (cp <= ARABIC_EXA_HI)) ||
            ((cp >= HEBREW_LO)     && (cp <= HEBREW_HI))     ||
            ((cp >= PRES_FORMS_LO) && (cp <= PRES_FORMS_HI));
      return rtl && (cp != CP_NEWLINE);
   endfunction

endpackage

### hdl/rr_if.sv
`timescale 1ns / 1ps

// Input channel: one decoded code point per transaction
interface rr_req_if;
   logic                      valid;
   logic                      ready;
   logic [rr_pkg::CP_W-1:0]   code_point;
   logic                      end_of_text;

   modport source (output valid, output code_point, output end_of_text, input ready);
   modport sink   (input valid, input code_point, input end_of_text, output ready);
endinterface

// Result channel: one reordered code point per transaction
interface rr_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rr_pkg::CP_W-1:0]   out_code_point;
   logic                      last_of_burst;

   modport source (output valid, output out_code_point, output last_of_burst, input ready);
   modport sink   (input valid, input out_code_point, input last_of_burst, output ready);
endinterface

### hdl/rr_stack_mem.sv
`timescale 1ns / 1ps

module rr_stack_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  logic [rr_pkg::CP_W-1:0] wr_data,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   output logic [rr_pkg::CP_W-1:0] rd_data
);

   logic [rr_pkg::CP_W-1:0] mem [DEPTH];
   logic [rr_pkg::CP_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds its data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/rr_ctrl.sv
`timescale 1ns / 1ps

module rr_ctrl #(
   parameter int RUN_DEPTH = 32,
   parameter int AW        = 5,
   parameter int CW        = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   rr_req_if.sink                  req_ch,
   input  logic                    out_free,
   output rr_pkg::rr_out_type      out,
   output logic                    wr_en,
   output logic [AW-1:0]           wr_addr,
   output logic [rr_pkg::CP_W-1:0] wr_data,
   output logic                    rd_en,
   output logic [AW-1:0]           rd_addr,
   input  logic [rr_pkg::CP_W-1:0] rd_data,
   output logic [CW-1:0]           count
);

   rr_pkg::rr_state_type    state_ff, state_in;
   rr_pkg::rr_next_type     next_ff, next_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           count_m1, count_m2;
   logic [rr_pkg::CP_W-1:0] cp_ff;
   logic                    eot_ff;
   logic                    accept;
   logic                    rtl;

   assign req_ch.ready = (state_ff == rr_pkg::ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rtl          = rr_pkg::is_rtl(req_ch.code_point);
   assign count_m1     = count_ff - CW'(1);
   assign count_m2     = count_ff - CW'(2);
   assign count        = count_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rr_pkg::ST_IDLE;
         next_ff  <= rr_pkg::NXT_DONE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         next_ff  <= next_in;
         count_ff <= count_in;
      end
   end

   // Held transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         cp_ff  <= req_ch.code_point;
         eot_ff <= req_ch.end_of_text;
      end
   end

   // Sequencer: push, release the run top first, then emit or push
   always_comb begin
      state_in = state_ff;
      next_in  = next_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_addr  = count_ff[AW-1:0];
      wr_data  = req_ch.code_point;
      rd_en    = 1'b0;
      rd_addr  = count_m1[AW-1:0];
      out.load = 1'b0;
      out.cp   = rd_data;
      out.last = 1'b0;

      unique case (state_ff)
         rr_pkg::ST_IDLE: begin
            if (accept) begin
               if (rtl && (count_ff < CW'(RUN_DEPTH))) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CW'(1);
                  if (req_ch.end_of_text) begin
                     next_in  = rr_pkg::NXT_DONE;
                     state_in = rr_pkg::ST_RD;
                  end
               end else if (rtl) begin
                  // full stack: release first, push afterwards
                  next_in  = rr_pkg::NXT_PUSH;
                  state_in = rr_pkg::ST_RD;
               end else begin
                  next_in  = rr_pkg::NXT_EMIT;
                  state_in = (count_ff == '0) ? rr_pkg::ST_EMIT : rr_pkg::ST_RD;
               end
            end
         end

         rr_pkg::ST_RD: begin
            rd_en    = 1'b1;
            state_in = rr_pkg::ST_OUT;
         end

         rr_pkg::ST_OUT: begin
            if (out_free) begin
               out.load = 1'b1;
               count_in = count_m1;
               if (count_ff == CW'(1)) begin
                  out.last = (next_ff == rr_pkg::NXT_DONE) ||
                             ((next_ff == rr_pkg::NXT_PUSH) && !eot_ff);
                  unique case (next_ff)
                     rr_pkg::NXT_EMIT: state_in = rr_pkg::ST_EMIT;
                     rr_pkg::NXT_PUSH: state_in = rr_pkg::ST_PUSH;
                     default:          state_in = rr_pkg::ST_IDLE;
                  endcase
               end else begin
                  // fetch the next entry while this one goes out
                  rd_en   = 1'b1;
                  rd_addr = count_m2[AW-1:0];
               end
            end
         end

         rr_pkg::ST_EMIT: begin
            out.cp = cp_ff;
            if (out_free) begin
               out.load = 1'b1;
               out.last = 1'b1;
               state_in = rr_pkg::ST_IDLE;
            end
         end

         rr_pkg::ST_PUSH: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = cp_ff;
            count_in = CW'(1);
            if (eot_ff) begin
               next_in  = rr_pkg::NXT_DONE;
               state_in = rr_pkg::ST_RD;
            end else begin
               state_in = rr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/rtl_run_reverser.sv
`timescale 1ns / 1ps

// Puts each contiguous right-to-left run (Hebrew, Arabic, Arabic Supplement,
// Arabic Extended-A, Arabic presentation forms; newline excluded) into visual
// order: such code points are held on a RUN_DEPTH-entry stack in a
// single-port-read memory, and any other code point or the end-of-text flag
// releases the run top first before the current code point goes out; a
// right-to-left code point that meets a full stack releases the run and is
// then pushed. One transaction is taken at a time. A right-to-left push
// writes the stack; a release reads it through the registered read port,
// fetching the next entry while the current one goes out, and delivers one
// entry per cycle while the output register is free; a code point passed on
// or pushed after the release follows it. A one-entry output register parts
// the result channel from the sequencer. The stack needs no clearing after
// reset.
module rtl_run_reverser #(
   parameter int RUN_DEPTH = 32
) (
   input  logic     clock,
   input  logic     reset,
   rr_req_if.sink   req_ch,
   rr_rsp_if.source rsp_ch
);

   localparam int AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
   localparam int CW = $clog2(RUN_DEPTH + 1);

   rr_pkg::rr_out_type      out;
   logic                    out_free;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [rr_pkg::CP_W-1:0] wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [rr_pkg::CP_W-1:0] rd_data;
   logic [CW-1:0]           count;
   logic                    rsp_valid_ff;
   logic [rr_pkg::CP_W-1:0] rsp_cp_ff;
   logic                    rsp_last_ff;

   rr_ctrl #(
      .RUN_DEPTH (RUN_DEPTH),
      .AW        (AW),
      .CW        (CW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .out_free (out_free),
      .out      (out),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .count    (count)
   );

   rr_stack_mem #(
      .DEPTH (RUN_DEPTH),
      .AW    (AW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out.load) begin
         rsp_cp_ff   <= out.cp;
         rsp_last_ff <= out.last;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_code_point = rsp_cp_ff;
   assign rsp_ch.last_of_burst  = rsp_last_ff;

`ifndef SYNTHESIS
   // A pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out.load |-> out_free)
      else $error("result loaded while output register occupied");

   // Run never exceeds the stack
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count <= CW'(RUN_DEPTH))
      else $error("run count beyond stack depth");

   // Stack is never read and written in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("stack read and write overlap");

   // A push leaves the stack one deeper
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (wr_en && !rd_en && (count != '0)) |=> (count == $past(count) + CW'(1)))
      else $error("push did not grow the run");
`endif

endmodule

### tb/sv/tb_rtl_run_reverser.sv
`timescale 1ns / 1ps

module tb_rtl_run_reverser;

   // Code point as carried on both channels
   typedef logic [rr_pkg::CP_W-1:0] cp_type;

   // One input transaction: a decoded code point and the end-of-text flag
   typedef struct packed {
      cp_type cp;
      logic   eot;
   } glyph_type;

   // One result transaction in visual order
   typedef struct packed {
      cp_type cp;
      logic   last;
   } visual_type;

   localparam int HOLD_DEPTH = 32;

   logic clock;
   logic reset;

   rr_req_if req_bus ();
   rr_rsp_if rsp_bus ();

   rtl_run_reverser #(
      .RUN_DEPTH (HOLD_DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   glyph_type       glyph_q[$];
   visual_type      visual_q[$];
   cp_type          run_hold[HOLD_DEPTH];
   int              run_len;
   int              mismatches;
   int              src_gap;
   int              sink_gap;
   bit              idle_on;
   logic            req_fire;

   // Clock, 4 ns period
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Known values on every input from time zero
   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.code_point  = '0;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready       = 1'b0;
   end

   // Hard stop if the block hangs
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic bit is_right_to_left(input cp_type c);
      if (c == rr_pkg::CP_NEWLINE)
         return 1'b0;
      return (c >= rr_pkg::HEBREW_LO && c <= rr_pkg::HEBREW_HI) ||
             (c >= rr_pkg::ARABIC_LO && c <= rr_pkg::ARABIC_HI) ||
             (c >= rr_pkg::ARABIC_SUP_LO && c <= rr_pkg::ARABIC_SUP_HI) ||
             (c >= rr_pkg::ARABIC_EXA_LO && c <= rr_pkg::ARABIC_EXA_HI) ||
             (c >= rr_pkg::PRES_FORMS_LO && c <= rr_pkg::PRES_FORMS_HI);
   endfunction

   // Expected visual output for one accepted code point
   task automatic reorder_glyph(input glyph_type g);
      visual_type burst[$];
      visual_type v;
      if (is_right_to_left(g.cp)) begin
         if (run_len >= HOLD_DEPTH) begin
            while (run_len > 0) begin
               run_len--;
               v.cp   = run_hold[run_len];
               v.last = 1'b0;
               burst.push_back(v);
            end
         end
         run_hold[run_len] = g.cp;
         run_len++;
         if (g.eot) begin
            while (run_len > 0) begin
               run_len--;
               v.cp   = run_hold[run_len];
               v.last = 1'b0;
               burst.push_back(v);
            end
         end
      end else begin
         while (run_len > 0) begin
            run_len--;
            v.cp   = run_hold[run_len];
            v.last = 1'b0;
            burst.push_back(v);
         end
         v.cp   = g.cp;
         v.last = 1'b0;
         burst.push_back(v);
      end
      if (burst.size() > 0)
         burst[burst.size()-1].last = 1'b1;
      foreach (burst[i])
         visual_q.push_back(burst[i]);
   endtask

   // Accept tracking, result check and prediction at the rising edge
   always @(posedge clock) begin
      visual_type want;
      glyph_type  took;
      req_fire <= !reset && req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (visual_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result cp=%h last=%b",
                           rsp_bus.out_code_point, rsp_bus.last_of_burst);
            end else begin
               want = visual_q.pop_front();
               if (rsp_bus.out_code_point !== want.cp ||
                   rsp_bus.last_of_burst !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected cp=%h last=%b, got cp=%h last=%b",
                              want.cp, want.last,
                              rsp_bus.out_code_point, rsp_bus.last_of_burst);
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            took.cp  = req_bus.code_point;
            took.eot = req_bus.end_of_text;
            reorder_glyph(took);
         end
      end
   end

   // Input driver: presents queued transactions with random gaps
   always @(negedge clock) begin
      glyph_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (src_gap > 0) begin
            src_gap       <= src_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (glyph_q.size() > 0) begin
            nxt = glyph_q.pop_front();
            req_bus.code_point  <= nxt.cp;
            req_bus.end_of_text <= nxt.eot;
            req_bus.valid       <= 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0)
               src_gap <= $urandom_range(1, 11);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result sink: ready with random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap      <= sink_gap - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (idle_on && $urandom_range(0, 5) == 0)
            sink_gap <= $urandom_range(1, 11);
      end
   end

   task automatic queue_glyph(input cp_type c, input logic e);
      glyph_type g;
      g.cp  = c;
      g.eot = e;
      glyph_q.push_back(g);
   endtask

   function automatic cp_type pick_rtl();
      case ($urandom_range(0, 4))
         0:       return cp_type'($urandom_range(rr_pkg::HEBREW_LO, rr_pkg::HEBREW_HI));
         1:       return cp_type'($urandom_range(rr_pkg::ARABIC_LO, rr_pkg::ARABIC_HI));
         2:       return cp_type'($urandom_range(rr_pkg::ARABIC_SUP_LO,
                                                 rr_pkg::ARABIC_SUP_HI));
         3:       return cp_type'($urandom_range(rr_pkg::ARABIC_EXA_LO,
                                                 rr_pkg::ARABIC_EXA_HI));
         default: return cp_type'($urandom_range(rr_pkg::PRES_FORMS_LO,
                                                 rr_pkg::PRES_FORMS_HI));
      endcase
   endfunction

   function automatic cp_type pick_other();
      case ($urandom_range(0, 3))
         0: return cp_type'($urandom_range(21'h20, 21'h7E));
         1: return rr_pkg::CP_NEWLINE;
         2: return cp_type'($urandom);
         default: begin
            // just outside each right-to-left block
            case ($urandom_range(0, 7))
               0:       return cp_type'(rr_pkg::HEBREW_LO - 1);
               1:       return cp_type'(rr_pkg::ARABIC_HI + 1);
               2:       return cp_type'(rr_pkg::ARABIC_SUP_LO - 1);
               3:       return cp_type'(rr_pkg::ARABIC_SUP_HI + 1);
               4:       return cp_type'(rr_pkg::ARABIC_EXA_LO - 1);
               5:       return cp_type'(rr_pkg::ARABIC_EXA_HI + 1);
               6:       return cp_type'(rr_pkg::PRES_FORMS_LO - 1);
               default: return cp_type'(rr_pkg::PRES_FORMS_HI + 1);
            endcase
         end
      endcase
   endfunction

   // Mostly runs closed by a left-to-right code point or end of text; some noise
   task automatic fill_random(input int target);
      int added;
      int len;
      int closer;
      added = 0;
      while (added < target) begin
         if ($urandom_range(0, 3) != 0) begin
            len    = ($urandom_range(0, 4) == 0) ? $urandom_range(28, 40)
                                                 : $urandom_range(1, 6);
            if (len > target - added)
               len = target - added;
            closer = $urandom_range(0, 19);
            for (int i = 0; i < len; i++)
               queue_glyph(pick_rtl(), (closer < 3) && (i == len - 1));
            if (closer >= 3)
               queue_glyph(pick_other(), closer < 6);
            added += len + ((closer >= 3) ? 1 : 0);
         end else begin
            queue_glyph(cp_type'($urandom), $urandom_range(0, 7) == 0);
            added++;
         end
      end
   endtask

   // Hold off until every queued transaction is in, every result is out
   // and no idle burst is still pending on either side
   task automatic wait_drain();
      do begin
         @(posedge clock);
         #1;
      end while (glyph_q.size() != 0 || req_bus.valid || visual_q.size() != 0 ||
                 src_gap != 0 || sink_gap != 0);
   endtask

   // Sequence of the run
   initial begin
      run_len    = 0;
      mismatches = 0;
      src_gap    = 0;
      sink_gap   = 0;
      idle_on    = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // Directed: block edges, newline, out-of-range values, both end-of-text forms
      queue_glyph(21'h000000, 1'b0);
      queue_glyph(cp_type'(rr_pkg::HEBREW_LO - 1), 1'b0);
      queue_glyph(rr_pkg::HEBREW_LO, 1'b0);
      queue_glyph(rr_pkg::HEBREW_HI, 1'b0);
      queue_glyph(rr_pkg::ARABIC_LO, 1'b0);
      queue_glyph(rr_pkg::ARABIC_HI, 1'b0);
      queue_glyph(cp_type'(rr_pkg::ARABIC_HI + 1), 1'b0);
      queue_glyph(cp_type'(rr_pkg::ARABIC_SUP_LO - 1), 1'b0);
      queue_glyph(rr_pkg::ARABIC_SUP_LO, 1'b0);
      queue_glyph(rr_pkg::ARABIC_SUP_HI, 1'b0);
      queue_glyph(cp_type'(rr_pkg::ARABIC_SUP_HI + 1), 1'b0);
      queue_glyph(cp_type'(rr_pkg::ARABIC_EXA_LO - 1), 1'b0);
      queue_glyph(rr_pkg::ARABIC_EXA_LO, 1'b0);
      queue_glyph(rr_pkg::ARABIC_EXA_HI, 1'b0);
      queue_glyph(rr_pkg::CP_NEWLINE, 1'b0);
      queue_glyph(cp_type'(rr_pkg::PRES_FORMS_LO - 1), 1'b0);
      queue_glyph(rr_pkg::PRES_FORMS_LO, 1'b0);
      queue_glyph(rr_pkg::PRES_FORMS_HI, 1'b1);
      queue_glyph(cp_type'(rr_pkg::PRES_FORMS_HI + 1), 1'b0);
      queue_glyph(21'h0005D0, 1'b0);
      queue_glyph(21'h000041, 1'b1);
      queue_glyph(21'h110000, 1'b0);
      queue_glyph(21'h1FFFFF, 1'b1);
      queue_glyph(21'h0006FF, 1'b1);
      wait_drain();

      // Random, with idling on both sides
      fill_random(40);
      wait_drain();

      // Random, no idling
      idle_on = 1'b0;
      fill_random(35);
      wait_drain();

      // Random, idling again
      idle_on = 1'b1;
      fill_random(35);
      wait_drain();

      // Last part: no idling
      idle_on = 1'b0;
      fill_random(26);
      wait_drain();

      repeat (40) @(posedge clock);
      if (visual_q.size() != 0)
         mismatches++;
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
hdl/rr_pkg.sv
hdl/rr_if.sv
hdl/rr_stack_mem.sv
hdl/rr_ctrl.sv
hdl/rtl_run_reverser.sv
tb/sv/tb_rtl_run_reverser.sv
